### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants and codes for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 5;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W    = 32;
  localparam int OUT_CNT_W = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [DATA_W-1:0] INT_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_QUERY      = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL_REJ   = 2'd1,
    ST_EMPTY_REJ  = 2'd2
  } status_t;

  // register index, taken from paddr word bit
  localparam logic REG_CAPACITY = 1'b0;

endpackage

### rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of 32-bit signed values in a circular store, one item in,
// one result out, with an APB-style port for the capacity register.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  req     | req_valid/req_stall  | mode, value
//  rsp     | rsp_valid/rsp_stall  | front_value, rear_value, entry_count,
//          |                      | is_empty, is_full, status
//  apb     | psel/penable/pready  | pwrite, paddr, pwdata, prdata
//
// One item per cycle while req_stall is low; the result appears in the cycle after
// acceptance, in the result register that also holds the registered store reads.
// Head, count and store are updated at the accepting edge, so the next item
// sees them at once. The store has no reset; head and count clear on rst.
// req_stall is high only while a result waits and rsp_stall is high.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [2:0]                         mode,
  input  logic signed [deq_pkg::DATA_W-1:0]  value,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic signed [deq_pkg::DATA_W-1:0]  front_value,
  output logic signed [deq_pkg::DATA_W-1:0]  rear_value,
  output logic [deq_pkg::OUT_CNT_W-1:0]      entry_count,
  output logic                               is_empty,
  output logic                               is_full,
  output logic [1:0]                         status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [deq_pkg::PADDR_W-1:0]        paddr,
  input  logic [deq_pkg::PDATA_W-1:0]        pwdata,
  output logic [deq_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [deq_pkg::DATA_W-1:0]  store [deq_pkg::DEPTH];

  logic [deq_pkg::IDX_W-1:0]   head_index;
  logic [deq_pkg::IDX_W-1:0]   head_index_next;
  logic [deq_pkg::CNT_W-1:0]   held_count;
  logic [deq_pkg::CNT_W-1:0]   held_count_next;
  logic [deq_pkg::CAP_W-1:0]   capacity;

  logic                        accept;
  logic                        reg_sel;
  logic [deq_pkg::CMP_W-1:0]   eff_cap;
  logic                        full_now;
  logic                        wr_en;
  logic [deq_pkg::IDX_W-1:0]   wr_addr;
  logic [deq_pkg::IDX_W-1:0]   head_dec;
  logic [deq_pkg::IDX_W-1:0]   head_inc;
  logic [deq_pkg::IDX_W-1:0]   rear_addr;
  logic [deq_pkg::IDX_W-1:0]   tail_addr;
  logic [deq_pkg::CNT_W-1:0]   count_dec;
  deq_pkg::status_t            status_next;

  // circular index add, single wrap, offset at most DEPTH
  function automatic logic [deq_pkg::IDX_W-1:0] wrap_add(
    input logic [deq_pkg::IDX_W-1:0] base,
    input logic [deq_pkg::CNT_W-1:0] off
  );
    logic [deq_pkg::CNT_W+deq_pkg::IDX_W:0] sum;
    sum = (deq_pkg::CNT_W+deq_pkg::IDX_W+1)'(base)
        + (deq_pkg::CNT_W+deq_pkg::IDX_W+1)'(off);
    if (sum >= (deq_pkg::CNT_W+deq_pkg::IDX_W+1)'(deq_pkg::DEPTH)) begin
      sum = sum - (deq_pkg::CNT_W+deq_pkg::IDX_W+1)'(deq_pkg::DEPTH);
    end
    return sum[deq_pkg::IDX_W-1:0];
  endfunction

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[deq_pkg::PADDR_W-1] == deq_pkg::REG_CAPACITY);
  assign prdata  = reg_sel ? deq_pkg::PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= deq_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[deq_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    if (deq_pkg::CMP_W'(capacity) > deq_pkg::CMP_W'(deq_pkg::DEPTH)) begin
      eff_cap = deq_pkg::CMP_W'(deq_pkg::DEPTH);
    end else begin
      eff_cap = deq_pkg::CMP_W'(capacity);
    end
  end

  assign full_now  = deq_pkg::CMP_W'(held_count) >= eff_cap;
  assign head_dec  = wrap_add(head_index, deq_pkg::CNT_W'(deq_pkg::DEPTH - 1));
  assign head_inc  = wrap_add(head_index, deq_pkg::CNT_W'(1));
  assign tail_addr = wrap_add(head_index, held_count);
  assign count_dec = held_count - deq_pkg::CNT_W'(1);

  always_comb begin
    head_index_next = head_index;
    held_count_next = held_count;
    wr_en           = 1'b0;
    wr_addr         = tail_addr;
    status_next     = deq_pkg::ST_OK;
    case (mode)
      deq_pkg::MODE_PUSH_FRONT: begin
        if (full_now) begin
          status_next = deq_pkg::ST_FULL_REJ;
        end else begin
          head_index_next = head_dec;
          held_count_next = held_count + deq_pkg::CNT_W'(1);
          wr_en           = 1'b1;
          wr_addr         = head_dec;
        end
      end
      deq_pkg::MODE_PUSH_REAR: begin
        if (full_now) begin
          status_next = deq_pkg::ST_FULL_REJ;
        end else begin
          held_count_next = held_count + deq_pkg::CNT_W'(1);
          wr_en           = 1'b1;
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (held_count == '0) begin
          status_next = deq_pkg::ST_EMPTY_REJ;
        end else begin
          head_index_next = head_inc;
          held_count_next = count_dec;
        end
      end
      deq_pkg::MODE_POP_REAR: begin
        if (held_count == '0) begin
          status_next = deq_pkg::ST_EMPTY_REJ;
        end else begin
          held_count_next = count_dec;
        end
      end
      default: begin
      end
    endcase
  end

  assign rear_addr = wrap_add(head_index_next, held_count_next - deq_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      held_count <= '0;
    end else if (accept) begin
      head_index <= head_index_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store[wr_addr] <= value;
    end
  end

  // result register with registered store reads and write bypass
  always_ff @(posedge clk) begin
    if (accept) begin
      if (held_count_next == '0) begin
        front_value <= deq_pkg::INT_MIN;
        rear_value  <= deq_pkg::INT_MIN;
      end else begin
        if (wr_en && (wr_addr == head_index_next)) begin
          front_value <= value;
        end else begin
          front_value <= store[head_index_next];
        end
        if (wr_en && (wr_addr == rear_addr)) begin
          rear_value <= value;
        end else begin
          rear_value <= store[rear_addr];
        end
      end
      entry_count <= deq_pkg::OUT_CNT_W'(held_count_next);
      is_empty    <= (held_count_next == '0);
      is_full     <= deq_pkg::CMP_W'(held_count_next) >= eff_cap;
      status      <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks double_ended_queue_unit against a shadow deque. A short table of
// items runs first: empty and full rejects, value extremes, the spare mode
// codes, a capacity cut below the held count, and capacities of zero and
// above the store depth. Then come random push and pop bursts under
// changing capacities and idle patterns. Every result is compared field by
// field with the predicted deque view.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]    front;
    logic [DATA_W-1:0]    rear;
    logic [OUT_CNT_W-1:0] count;
    logic                 empty;
    logic                 full;
    status_t              st;
  } deque_view_t;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [2:0]        op;
    logic [DATA_W-1:0] val;
    logic              typed;
    deque_view_t       res;
  } row_t;

  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;

  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'({REG_CAPACITY, 2'b00});

  localparam deque_view_t UNTYPED = '{32'd0, 32'd0, 5'd0, 1'b0, 1'b0, ST_OK};
  localparam deque_view_t DRAINED = '{INT_MIN, INT_MIN, 5'd0, 1'b1, 1'b0, ST_OK};
  localparam deque_view_t POP_ON_EMPTY =
    '{INT_MIN, INT_MIN, 5'd0, 1'b1, 1'b0, ST_EMPTY_REJ};

  localparam row_t DIR_ROWS [25] = '{
    '{ROW_ITEM, MODE_POP_FRONT,  32'h0000_0000, 1'b1, POP_ON_EMPTY},
    '{ROW_ITEM, MODE_POP_REAR,   32'hFFFF_FFFF, 1'b1, POP_ON_EMPTY},
    '{ROW_ITEM, MODE_QUERY,      32'h0000_0000, 1'b1, DRAINED},
    '{ROW_ITEM, MODE_PUSH_REAR,  32'h7FFF_FFFF, 1'b1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0, ST_OK}},
    '{ROW_ITEM, MODE_PUSH_FRONT, 32'h8000_0000, 1'b1,
      '{32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0, 1'b0, ST_OK}},
    '{ROW_ITEM, MODE_PUSH_FRONT, 32'h0000_0000, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_PUSH_REAR,  32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_SPARE_A,    32'h5555_5555, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_SPARE_B,    32'hAAAA_AAAA, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_SPARE_C,    32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_POP_REAR,   32'hA5A5_A5A5, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_POP_FRONT,  32'h5A5A_5A5A, 1'b0, UNTYPED},
    // capacity cut below the two held entries
    '{ROW_CAP,  MODE_QUERY,      32'd1,         1'b0, UNTYPED},
    '{ROW_ITEM, MODE_PUSH_FRONT, 32'h1234_5678, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_PUSH_REAR,  32'h0000_0000, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_POP_FRONT,  32'h0000_0000, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_POP_REAR,   32'h0000_0000, 1'b1, DRAINED},
    // zero capacity: full and empty at once
    '{ROW_CAP,  MODE_QUERY,      32'd0,         1'b0, UNTYPED},
    '{ROW_ITEM, MODE_PUSH_FRONT, 32'h0000_0001, 1'b1,
      '{INT_MIN, INT_MIN, 5'd0, 1'b1, 1'b1, ST_FULL_REJ}},
    '{ROW_ITEM, MODE_PUSH_REAR,  32'hFFFF_FFFF, 1'b1,
      '{INT_MIN, INT_MIN, 5'd0, 1'b1, 1'b1, ST_FULL_REJ}},
    '{ROW_ITEM, MODE_POP_FRONT,  32'h0000_0000, 1'b1,
      '{INT_MIN, INT_MIN, 5'd0, 1'b1, 1'b1, ST_EMPTY_REJ}},
    // capacity above depth saturates
    '{ROW_CAP,  MODE_QUERY,      32'd31,        1'b0, UNTYPED},
    '{ROW_ITEM, MODE_PUSH_REAR,  32'h7FFF_FFFF, 1'b1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0, ST_OK}},
    '{ROW_ITEM, MODE_PUSH_FRONT, 32'h8000_0000, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_QUERY,      32'h0000_0000, 1'b0, UNTYPED}
  };

  localparam int SEG_ITEMS = 140;
  localparam int SEG_CAP [9] = '{16, 31, 1, 7, 0, 3, 2, 16, 12};
  localparam int SEND_IDLE [3] = '{26, 65, 0};
  localparam int RECV_IDLE [3] = '{65, 26, 0};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [2:0]               mode = MODE_QUERY;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic [OUT_CNT_W-1:0]     entry_count;
  logic                     is_empty;
  logic                     is_full;
  logic [1:0]               status;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  logic [DATA_W-1:0] shadow_slots [DEPTH];
  int                shadow_head = 0;
  int                shadow_count = 0;
  logic [CAP_W-1:0]  shadow_cap = CAP_RESET;
  deque_view_t       deque_views [$];
  int                mismatches = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;

  double_ended_queue_unit i_dut (.*);

  always #2 clk = ~clk;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic deque_view_t apply_op(logic [2:0] op, logic [DATA_W-1:0] val);
    deque_view_t v;
    int          lim;
    logic        full;
    lim = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    full = (shadow_count >= lim);
    v.st = ST_OK;
    case (op)
      MODE_PUSH_FRONT: begin
        if (full) begin
          v.st = ST_FULL_REJ;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_slots[shadow_head] = val;
          shadow_count++;
        end
      end
      MODE_PUSH_REAR: begin
        if (full) begin
          v.st = ST_FULL_REJ;
        end else begin
          shadow_slots[(shadow_head + shadow_count) % DEPTH] = val;
          shadow_count++;
        end
      end
      MODE_POP_FRONT: begin
        if (shadow_count == 0) begin
          v.st = ST_EMPTY_REJ;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      MODE_POP_REAR: begin
        if (shadow_count == 0) begin
          v.st = ST_EMPTY_REJ;
        end else begin
          shadow_count--;
        end
      end
      default: ;
    endcase
    v.front = INT_MIN;
    v.rear  = INT_MIN;
    if (shadow_count != 0) begin
      v.front = shadow_slots[shadow_head];
      v.rear  = shadow_slots[(shadow_head + shadow_count - 1) % DEPTH];
    end
    v.count = OUT_CNT_W'(shadow_count);
    v.empty = (shadow_count == 0);
    v.full  = (shadow_count >= lim);
    return v;
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [DATA_W-1:0] val,
                           input logic typed, input deque_view_t res);
    deque_view_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= op;
    value     <= val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    v = apply_op(op, val);
    deque_views = {deque_views, (typed ? res : v)};
  endtask

  task automatic finish_items();
    req_valid <= 1'b0;
    while (deque_views.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [PDATA_W-1:0] wd,
                          output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CAP_ADDR;
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, PDATA_W'(c), rd);
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    shadow_cap = c;
    check_field("capacity_in_use", PDATA_W'(c), rd);
  endtask

  always @(posedge clk) begin
    deque_view_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (deque_views.size() == 0) begin
          $display("%0t ns: result expected none, got count %0d status %0d",
                   $time, entry_count, status);
          mismatches++;
        end else begin
          want = deque_views.pop_front();
          check_field("front_value", want.front, front_value);
          check_field("rear_value", want.rear, rear_value);
          check_field("entry_count", 32'(want.count), 32'(entry_count));
          check_field("is_empty", 32'(want.empty), 32'(is_empty));
          check_field("is_full", 32'(want.full), 32'(is_full));
          check_field("status", 32'(want.st), 32'(status));
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    logic [PDATA_W-1:0] rd;
    logic [2:0]         op;
    logic [DATA_W-1:0]  val;
    int                 push_bias;
    int                 pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("capacity_in_use", PDATA_W'(CAP_RESET), rd);

    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CAP) begin
        finish_items();
        set_capacity(CAP_W'(DIR_ROWS[i].val));
      end else begin
        send_item(DIR_ROWS[i].op, DIR_ROWS[i].val, DIR_ROWS[i].typed, DIR_ROWS[i].res);
      end
    end
    finish_items();

    for (int seg = 0; seg < 9; seg++) begin
      send_idle_pct = SEND_IDLE[seg / 3];
      recv_idle_pct = RECV_IDLE[seg / 3];
      set_capacity((seg == 7) ? CAP_W'($urandom_range(31)) : CAP_W'(SEG_CAP[seg]));
      push_bias = 50;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // bursts that lean towards filling or emptying
        if (n % 24 == 0) push_bias = $urandom_range(1) ? 80 : 20;
        pick = $urandom_range(99);
        if (pick < 8) begin
          op = 3'($urandom_range(MODE_SPARE_C, MODE_QUERY));
        end else if ($urandom_range(99) < push_bias) begin
          op = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
        end else begin
          op = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
        end
        case ($urandom_range(9))
          0:       val = INT_MIN;
          1:       val = 32'h7FFF_FFFF;
          2:       val = '0;
          3:       val = '1;
          default: val = $urandom;
        endcase
        send_item(op, val, 1'b0, UNTYPED);
      end
      finish_items();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/deq_pkg.sv
rtl/double_ended_queue_unit.sv
tb/sv/testbench.sv
